>>> hdl/tvs_pkg.sv
// Trilinear volume sampler: shared types, constants and coordinate helper.
// Used by the top level; depends on nothing.
`default_nettype none

package tvs_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_LAYERS = 64;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int LAY_W  = $clog2(MAX_LAYERS);
    localparam int ADDR_W = ROW_W + COL_W + LAY_W;

    localparam int VOX_IDX_W = 6;
    localparam int VOXEL_W   = 16;
    localparam int CRD_W     = 16;
    localparam int FRAC_W    = 8;
    localparam int IDX_W     = CRD_W - FRAC_W - 1;
    localparam int CW        = 18;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int SAMPLE_W  = 24;
    localparam int WRC_W     = 2 * FRAC_W + 1;
    localparam int WGT_W     = 3 * FRAC_W + 1;
    localparam int ACC_W     = 42;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic                      mode;
        logic [VOX_IDX_W-1:0]      voxel_row;
        logic [VOX_IDX_W-1:0]      voxel_col;
        logic [VOX_IDX_W-1:0]      voxel_layer;
        logic signed [VOXEL_W-1:0] voxel_value;
        logic signed [CRD_W-1:0]   query_col;
        logic signed [CRD_W-1:0]   query_row;
        logic signed [CRD_W-1:0]   query_layer;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       in_range;
    } t_out_item;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
    } t_axis;

    // Shift a 1-based Q8.8 coordinate to 0-based and check it against the dimension.
    function automatic t_axis axis_prep(logic signed [CRD_W-1:0] q, logic [DIM_W-1:0] dim);
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] lim;
        t_axis a;
        c     = $signed({{(CW-CRD_W){q[CRD_W-1]}}, q}) - 18'sd256;
        lim   = $signed({{(CW-DIM_W){1'b0}}, dim}) - 18'sd1;
        lim   = lim <<< FRAC_W;
        a.ok  = (c >= 18'sd0) && (c <= lim);
        a.idx = c[FRAC_W +: IDX_W];
        a.frac = c[FRAC_W-1:0];
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tvs_ram.sv
// Single-port synchronous voxel memory with registered read data.
// Generic; no package dependency.
`default_nettype none

module tvs_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

>>> hdl/trilinear_volume_sampler.sv
// Trilinear volume sampler top level: sequencer, weight and blend datapath.
// Depends on tvs_pkg and tvs_ram.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): a load item
// (mode 0) writes one voxel in the cycle it is accepted and returns nothing;
// a load outside the store is dropped. A sample item (mode 1) returns one
// item on the output channel (o_out_valid / i_out_stall, payload o_out_item).
// A sample in range passes from acceptance to a registered result through
// a setup state forming the row-column weight products, a run state that
// reads the eight corners from the single-port volume memory (one read per
// cycle), a drain of the multiply and accumulate, and a result state.
// A sample out of range goes straight to the result state. The input
// stalls while a sample is in work, so a new sample is taken only once the
// last result is registered, and loads are taken one per cycle in between.
// The output register holds its item while i_out_stall is high; a finished
// result waits in the sequencer until that register is free.
// Reset clears control state and sets each dimension register to 64; the
// volume memory is not cleared and must be loaded before it is sampled.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered.
`default_nettype none

module trilinear_volume_sampler (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire tvs_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output tvs_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [tvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tvs_pkg::DIM_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state                                   r_state;
    logic [tvs_pkg::DIM_W-1:0]                r_rows, r_cols, r_layers;
    logic [tvs_pkg::IDX_W-1:0]                r_ridx, r_cidx, r_lidx;
    logic [tvs_pkg::FRAC_W-1:0]               r_fr, r_fc, r_fl;
    logic                                     r_inr;
    logic [2:0]                               r_cnt;
    logic [tvs_pkg::WRC_W-1:0]                r_wrc [4];
    logic [tvs_pkg::WGT_W-1:0]                r_w;
    logic                                     r_rv, r_pv;
    logic signed [tvs_pkg::ACC_W-1:0]         r_prod, r_acc;
    logic                                     r_out_valid;
    tvs_pkg::t_out_item                       r_out;

    logic                                     in_acc;
    logic [tvs_pkg::DIM_W-1:0]                dim_r, dim_c, dim_l;
    tvs_pkg::t_axis                           ax_r, ax_c, ax_l;
    logic                                     load_ok;
    logic                                     ram_we;
    logic [tvs_pkg::ADDR_W-1:0]               ram_addr, load_addr, corner_addr;
    logic [tvs_pkg::VOXEL_W-1:0]              ram_rdata;
    logic [tvs_pkg::ROW_W-1:0]                c_row;
    logic [tvs_pkg::COL_W-1:0]                c_col;
    logic [tvs_pkg::LAY_W-1:0]                c_lay;
    logic [tvs_pkg::FRAC_W:0]                 wr0, wr1, wc0, wc1, wl_sel;
    logic                                     out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        dim_r = (32'(r_rows) < 32'(tvs_pkg::MAX_ROWS)) ?
                r_rows : tvs_pkg::DIM_W'(tvs_pkg::MAX_ROWS);
        dim_c = (32'(r_cols) < 32'(tvs_pkg::MAX_COLS)) ?
                r_cols : tvs_pkg::DIM_W'(tvs_pkg::MAX_COLS);
        dim_l = (32'(r_layers) < 32'(tvs_pkg::MAX_LAYERS)) ?
                r_layers : tvs_pkg::DIM_W'(tvs_pkg::MAX_LAYERS);
        ax_r = tvs_pkg::axis_prep(i_in_item.query_row, dim_r);
        ax_c = tvs_pkg::axis_prep(i_in_item.query_col, dim_c);
        ax_l = tvs_pkg::axis_prep(i_in_item.query_layer, dim_l);
    end

    always_comb begin
        load_ok = (32'(i_in_item.voxel_row) < 32'(tvs_pkg::MAX_ROWS))
               && (32'(i_in_item.voxel_col) < 32'(tvs_pkg::MAX_COLS))
               && (32'(i_in_item.voxel_layer) < 32'(tvs_pkg::MAX_LAYERS));
        load_addr = tvs_pkg::ADDR_W'(i_in_item.voxel_row)
                  + tvs_pkg::ADDR_W'(i_in_item.voxel_col)
                    * tvs_pkg::ADDR_W'(tvs_pkg::MAX_ROWS)
                  + tvs_pkg::ADDR_W'(i_in_item.voxel_layer)
                    * tvs_pkg::ADDR_W'(tvs_pkg::MAX_ROWS * tvs_pkg::MAX_COLS);
        c_row = tvs_pkg::ROW_W'(r_ridx)
              + tvs_pkg::ROW_W'(r_cnt[2] && (r_fr != '0));
        c_col = tvs_pkg::COL_W'(r_cidx)
              + tvs_pkg::COL_W'(r_cnt[1] && (r_fc != '0));
        c_lay = tvs_pkg::LAY_W'(r_lidx)
              + tvs_pkg::LAY_W'(r_cnt[0] && (r_fl != '0));
        corner_addr = tvs_pkg::ADDR_W'(c_row)
                    + tvs_pkg::ADDR_W'(c_col) * tvs_pkg::ADDR_W'(tvs_pkg::MAX_ROWS)
                    + tvs_pkg::ADDR_W'(c_lay)
                      * tvs_pkg::ADDR_W'(tvs_pkg::MAX_ROWS * tvs_pkg::MAX_COLS);
        ram_we   = in_acc && (i_in_item.mode == tvs_pkg::MODE_LOAD) && load_ok;
        ram_addr = (r_state == S_IDLE) ? load_addr : corner_addr;
    end

    always_comb begin
        wr1    = {1'b0, r_fr};
        wr0    = 9'd256 - wr1;
        wc1    = {1'b0, r_fc};
        wc0    = 9'd256 - wc1;
        wl_sel = r_cnt[0] ? {1'b0, r_fl} : (9'd256 - {1'b0, r_fl});
    end

    tvs_ram #(
        .ADDR_W (tvs_pkg::ADDR_W),
        .DATA_W (tvs_pkg::VOXEL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_item.voxel_value),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= tvs_pkg::DIM_RESET;
            r_cols      <= tvs_pkg::DIM_RESET;
            r_layers    <= tvs_pkg::DIM_RESET;
            r_cnt       <= '0;
            r_rv        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tvs_pkg::CFG_ROWS:   r_rows   <= i_cfg_data;
                    tvs_pkg::CFG_COLS:   r_cols   <= i_cfg_data;
                    tvs_pkg::CFG_LAYERS: r_layers <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            r_rv <= (r_state == S_RUN);
            r_pv <= r_rv;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_item.mode == tvs_pkg::MODE_SAMPLE)) begin
                        r_inr  <= ax_r.ok && ax_c.ok && ax_l.ok;
                        r_ridx <= ax_r.idx;
                        r_cidx <= ax_c.idx;
                        r_lidx <= ax_l.idx;
                        r_fr   <= ax_r.frac;
                        r_fc   <= ax_c.frac;
                        r_fl   <= ax_l.frac;
                        r_state <= (ax_r.ok && ax_c.ok && ax_l.ok) ? S_SETUP : S_DONE;
                    end
                end
                S_SETUP: begin
                    r_wrc[0] <= tvs_pkg::WRC_W'(wr0 * wc0);
                    r_wrc[1] <= tvs_pkg::WRC_W'(wr0 * wc1);
                    r_wrc[2] <= tvs_pkg::WRC_W'(wr1 * wc0);
                    r_wrc[3] <= tvs_pkg::WRC_W'(wr1 * wc1);
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_RUN;
                end
                S_RUN: begin
                    r_w   <= tvs_pkg::WGT_W'(r_wrc[r_cnt[2:1]] * wl_sel);
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rv && !r_pv) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.in_range     <= r_inr;
                        r_out.sample_value <= r_inr ?
                            r_acc[2*tvs_pkg::FRAC_W +: tvs_pkg::SAMPLE_W] : '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (r_rv) begin
                r_prod <= $signed(ram_rdata) * $signed({1'b0, r_w});
            end
            if (r_pv) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

endmodule

`default_nettype wire
